@@ hdl/isl_pkg.sv @@
// shared types, constants and helpers for the indexed sequence list
package isl_pkg;

    // list geometry
    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;

    // derived widths
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = 5;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int OUT_W  = 32;
    localparam int CNTO_W = 5;
    localparam int EXT_W  = WORD_BITS + OUT_W;

    // command codes
    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_PREPEND      = 3'd1,
        CMD_REMOVE_LAST  = 3'd2,
        CMD_REMOVE_FIRST = 3'd3,
        CMD_READ         = 3'd4,
        CMD_WRITE        = 3'd5,
        CMD_INSERT       = 3'd6,
        CMD_REMOVE_AT    = 3'd7
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // cell array operation chosen by the decoder
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE,
        OP_DROP_LAST
    } t_op_kind;

    // input command transfer
    typedef struct packed {
        t_cmd                    cmd;
        logic [POS_W-1:0]        position;
        logic signed [OUT_W-1:0] word_in;
    } t_cmd_item;

    // result transfer
    typedef struct packed {
        t_status                 status;
        logic signed [OUT_W-1:0] word_out;
        logic [CNTO_W-1:0]       count;
        logic signed [OUT_W-1:0] first_word;
        logic signed [OUT_W-1:0] last_word;
    } t_result;

    // decoder to store
    typedef struct packed {
        t_op_kind         kind;
        logic [IDX_W-1:0] index;
        t_status          status;
        logic             rd;
    } t_op;

    // store view after the operation
    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic [WORD_BITS-1:0] rd_word;
        logic [WORD_BITS-1:0] first_word;
        logic [WORD_BITS-1:0] last_word;
    } t_view;

    // cut or zero extend a stored word to the result field
    function automatic logic [OUT_W-1:0] to_out_word(input logic [WORD_BITS-1:0] w);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(w);
        return ext[OUT_W-1:0];
    endfunction

    // cut or zero extend an input word to the stored width
    function automatic logic [WORD_BITS-1:0] to_cell_word(input logic [OUT_W-1:0] w);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(w);
        return ext[WORD_BITS-1:0];
    endfunction

endpackage

@@ hdl/indexed_sequence_list_unit.sv @@
// top level of the indexed sequence list: command register, decode, cells, result register
//
//  channel   | ports                        | transfer when
//  ----------+------------------------------+---------------------------------
//  command   | i_start, o_busy, i_cmd       | i_start high and o_busy low
//  result    | o_valid, o_result            | o_valid high, one cycle per result
//
// one command can be taken every cycle while o_busy is low; after the transfer its result
// passes the command register, then the cell update and result register.
// the cells shift all at once, so every command costs one pass through the row.
// synchronous reset empties the list; o_busy is high during reset, is registered so
// it falls only after reset has been released, and is low from then on.
// results are never held back, so nothing inside ever stalls.
module indexed_sequence_list_unit import isl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_cmd_item i_cmd,
    output logic      o_valid,
    output t_result   o_result
);

    logic             r_busy;
    logic             r_in_valid;
    t_cmd_item        r_in;
    logic             r_out_valid;
    t_result          r_out;
    logic [CNT_W-1:0] w_fill;
    t_op              w_op;
    t_view            w_view;
    t_result          n_out;

    // busy only around reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_in <= i_cmd;
        end
    end

    isl_decode u_decode (
        .i_item (r_in),
        .i_fill (w_fill),
        .o_op   (w_op)
    );

    isl_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_op    (w_op),
        .i_word  (to_cell_word(r_in.word_in)),
        .o_fill  (w_fill),
        .o_view  (w_view)
    );

    // result assembly
    always_comb begin
        n_out.status     = w_op.status;
        n_out.word_out   = to_out_word(w_view.rd_word);
        n_out.count      = CNTO_W'(w_view.count);
        n_out.first_word = to_out_word(w_view.first_word);
        n_out.last_word  = to_out_word(w_view.last_word);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_busy   = r_busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ hdl/isl_decode.sv @@
// command decode: range, empty and full checks, choice of cell operation
module isl_decode import isl_pkg::*; (
    input  t_cmd_item        i_item,
    input  logic [CNT_W-1:0] i_fill,
    output t_op              o_op
);

    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_fill;
    logic             w_pos_lt;
    logic             w_pos_le;
    logic             w_full;
    logic             w_empty;

    // index compares against the current fill
    assign w_pos    = CMP_W'(i_item.position);
    assign w_fill   = CMP_W'(i_fill);
    assign w_pos_lt = w_pos < w_fill;
    assign w_pos_le = w_pos <= w_fill;
    assign w_full   = i_fill == CNT_W'(CAPACITY);
    assign w_empty  = i_fill == '0;

    // status and operation per command
    always_comb begin
        o_op.kind   = OP_NONE;
        o_op.index  = w_pos[IDX_W-1:0];
        o_op.status = ST_OK;
        o_op.rd     = 1'b0;
        case (i_item.cmd)
            CMD_APPEND: begin
                o_op.index = i_fill[IDX_W-1:0];
                if (w_full) o_op.status = ST_FULL;
                else        o_op.kind   = OP_INSERT;
            end
            CMD_PREPEND: begin
                o_op.index = '0;
                if (w_full) o_op.status = ST_FULL;
                else        o_op.kind   = OP_INSERT;
            end
            CMD_REMOVE_LAST: begin
                if (w_empty) o_op.status = ST_EMPTY;
                else         o_op.kind   = OP_DROP_LAST;
            end
            CMD_REMOVE_FIRST: begin
                o_op.index = '0;
                if (w_empty) o_op.status = ST_EMPTY;
                else         o_op.kind   = OP_REMOVE;
            end
            CMD_READ: begin
                if (!w_pos_lt) o_op.status = ST_RANGE;
                else           o_op.rd     = 1'b1;
            end
            CMD_WRITE: begin
                if (!w_pos_lt) o_op.status = ST_RANGE;
                else           o_op.kind   = OP_WRITE;
            end
            CMD_INSERT: begin
                if (!w_pos_le)   o_op.status = ST_RANGE;
                else if (w_full) o_op.status = ST_FULL;
                else             o_op.kind   = OP_INSERT;
            end
            CMD_REMOVE_AT: begin
                if (!w_pos_lt) o_op.status = ST_RANGE;
                else           o_op.kind   = OP_REMOVE;
            end
            default: begin
                o_op.kind = OP_NONE;
            end
        endcase
    end

endmodule

@@ hdl/isl_store.sv @@
// cell row with parallel shift for insert and remove, plus fill count
module isl_store import isl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_op                  i_op,
    input  logic [WORD_BITS-1:0] i_word,
    output logic [CNT_W-1:0]     o_fill,
    output t_view                o_view
);

    logic [WORD_BITS-1:0] r_cells [CAPACITY];
    logic [WORD_BITS-1:0] n_cells [CAPACITY];
    logic [CNT_W-1:0]     r_fill;
    logic [CNT_W-1:0]     n_fill;
    logic [CNT_W-1:0]     w_last_pos;

    // next value of each cell
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_prev;
        logic [WORD_BITS-1:0] w_next;
        logic                 w_at;
        logic                 w_above;

        if (g > 0) begin : g_prev
            assign w_prev = r_cells[g-1];
        end else begin : g_no_prev
            assign w_prev = r_cells[g];
        end
        if (g < CAPACITY - 1) begin : g_next
            assign w_next = r_cells[g+1];
        end else begin : g_no_next
            assign w_next = r_cells[g];
        end

        assign w_at    = IDX_W'(g) == i_op.index;
        assign w_above = IDX_W'(g) > i_op.index;

        always_comb begin
            n_cells[g] = r_cells[g];
            case (i_op.kind)
                OP_WRITE: begin
                    if (w_at) n_cells[g] = i_word;
                end
                OP_INSERT: begin
                    if (w_at)         n_cells[g] = i_word;
                    else if (w_above) n_cells[g] = w_prev;
                end
                OP_REMOVE: begin
                    if (w_at || w_above) n_cells[g] = w_next;
                end
                default: begin
                    n_cells[g] = r_cells[g];
                end
            endcase
        end
    end

    // next fill count
    always_comb begin
        case (i_op.kind)
            OP_INSERT:    n_fill = r_fill + CNT_W'(1);
            OP_REMOVE:    n_fill = r_fill - CNT_W'(1);
            OP_DROP_LAST: n_fill = r_fill - CNT_W'(1);
            default:      n_fill = r_fill;
        endcase
    end

    // cells hold no reset value
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cells[i] <= n_cells[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_valid) begin
            r_fill <= n_fill;
        end
    end

    // view of the list after this command
    assign w_last_pos = n_fill - CNT_W'(1);

    always_comb begin
        o_view.count      = n_fill;
        o_view.rd_word    = i_op.rd ? r_cells[i_op.index] : '0;
        o_view.first_word = (n_fill != '0) ? n_cells[0] : '0;
        o_view.last_word  = (n_fill != '0) ? n_cells[w_last_pos[IDX_W-1:0]] : '0;
    end

    assign o_fill = r_fill;

endmodule

@@ dv/indexed_sequence_list_unit_test.sv @@
// testbench for the indexed sequence list: command stimulus, list mirror and result checks
`timescale 1ns / 100ps

import isl_pkg::*;

// mirror of the list contents, with the results each accepted command should give
class list_mirror;

    logic [WORD_BITS-1:0] cells [CAPACITY];
    int                   fill;
    t_result              expected_results [$];
    int                   fails;

    function new();
        fill  = 0;
        fails = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // shift the cells from the index up by one and place the word there
    function void open_gap(int at, logic [WORD_BITS-1:0] w);
        for (int i = fill; i > at; i--) begin
            cells[i] = cells[i-1];
        end
        cells[at] = w;
        fill++;
    endfunction

    // shift the cells behind the index down by one
    function void close_gap(int at);
        for (int i = at; i + 1 < fill; i++) begin
            cells[i] = cells[i+1];
        end
        fill--;
    endfunction

    // apply one accepted command and queue the result it must produce
    function void note_command(t_cmd_item c);
        t_result              r;
        int                   pos;
        logic [WORD_BITS-1:0] w;
        pos = int'(c.position);
        w   = WORD_BITS'($unsigned(c.word_in));
        r   = '0;
        r.status = ST_OK;
        case (c.cmd)
            CMD_APPEND: begin
                if (fill >= CAPACITY) r.status = ST_FULL;
                else begin
                    cells[fill] = w;
                    fill++;
                end
            end
            CMD_PREPEND: begin
                if (fill >= CAPACITY) r.status = ST_FULL;
                else open_gap(0, w);
            end
            CMD_REMOVE_LAST: begin
                if (fill == 0) r.status = ST_EMPTY;
                else fill--;
            end
            CMD_REMOVE_FIRST: begin
                if (fill == 0) r.status = ST_EMPTY;
                else close_gap(0);
            end
            CMD_READ: begin
                if (pos >= fill) r.status = ST_RANGE;
                else r.word_out = OUT_W'(cells[pos]);
            end
            CMD_WRITE: begin
                if (pos >= fill) r.status = ST_RANGE;
                else cells[pos] = w;
            end
            CMD_INSERT: begin
                // index check comes before the capacity check
                if (pos > fill) r.status = ST_RANGE;
                else if (fill >= CAPACITY) r.status = ST_FULL;
                else open_gap(pos, w);
            end
            CMD_REMOVE_AT: begin
                if (pos >= fill) r.status = ST_RANGE;
                else close_gap(pos);
            end
            default: begin
                r.status = ST_OK;
            end
        endcase
        r.count      = CNTO_W'(fill);
        r.first_word = (fill > 0) ? OUT_W'(cells[0]) : '0;
        r.last_word  = (fill > 0) ? OUT_W'(cells[fill-1]) : '0;
        expected_results.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(t_result got);
        t_result want;
        bit      bad;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            fails++;
            return;
        end
        want = expected_results.pop_front();
        bad  = 1'b0;
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            bad = 1'b1;
        end
        if (got.word_out !== want.word_out) begin
            $display("%0t: word_out expected %h actual %h", $time, want.word_out, got.word_out);
            bad = 1'b1;
        end
        if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
            bad = 1'b1;
        end
        if (got.first_word !== want.first_word) begin
            $display("%0t: first_word expected %h actual %h", $time, want.first_word,
                     got.first_word);
            bad = 1'b1;
        end
        if (got.last_word !== want.last_word) begin
            $display("%0t: last_word expected %h actual %h", $time, want.last_word,
                     got.last_word);
            bad = 1'b1;
        end
        if (bad) fails++;
    endfunction

endclass

module indexed_sequence_list_unit_test;

    localparam int RANDOM_ITEMS = 1650;
    localparam int STALL_LIMIT  = 4000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_start;
    logic      o_busy;
    t_cmd_item i_cmd;
    logic      o_valid;
    t_result   o_result;

    list_mirror mirror = new();
    int         stall_cycles = 0;

    indexed_sequence_list_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                mirror.check_result(o_result);
            end
            if (i_start && !o_busy) begin
                mirror.note_command(i_cmd);
            end
            if (o_valid || (i_start && !o_busy)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic t_cmd_item make_cmd(t_cmd c, int pos, logic [31:0] w);
        t_cmd_item it;
        it.cmd      = c;
        it.position = POS_W'(pos);
        it.word_in  = w;
        return it;
    endfunction

    // offer one command, with random idle cycles ahead of it when may_idle is set, and wait for the transfer
    task automatic send_command(t_cmd_item c, bit may_idle);
        if (may_idle) begin
            while ($urandom_range(0, 99) < 32) begin
                @(negedge i_clk);
                i_start <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
    endtask

    initial begin
        t_cmd_item   it;
        int          lvl;
        int          roll;
        bit          growing;
        bit          quiet;
        logic [31:0] w;

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list rejections, field extremes, unused fields, every command
        send_command(make_cmd(CMD_REMOVE_LAST, 0, 32'h0), 1'b0);
        send_command(make_cmd(CMD_REMOVE_FIRST, 31, 32'hFFFF_FFFF), 1'b0);
        send_command(make_cmd(CMD_READ, 0, 32'h0), 1'b0);
        send_command(make_cmd(CMD_WRITE, 0, 32'h1111_1111), 1'b0);
        send_command(make_cmd(CMD_REMOVE_AT, 0, 32'h0), 1'b0);
        send_command(make_cmd(CMD_INSERT, 1, 32'h2222_2222), 1'b0);
        send_command(make_cmd(CMD_INSERT, 0, 32'h8000_0000), 1'b0);
        send_command(make_cmd(CMD_APPEND, 31, 32'h7FFF_FFFF), 1'b0);
        send_command(make_cmd(CMD_PREPEND, 17, 32'hFFFF_FFFF), 1'b0);
        send_command(make_cmd(CMD_READ, 31, 32'hFFFF_FFFF), 1'b0);
        send_command(make_cmd(CMD_READ, 2, 32'h0), 1'b0);
        send_command(make_cmd(CMD_WRITE, 1, 32'h0), 1'b0);
        send_command(make_cmd(CMD_INSERT, 3, 32'h1234_5678), 1'b0);
        send_command(make_cmd(CMD_REMOVE_AT, 1, 32'h0), 1'b0);
        send_command(make_cmd(CMD_READ, 3, 32'h0), 1'b0);
        send_command(make_cmd(CMD_WRITE, 3, 32'h5555_5555), 1'b0);
        send_command(make_cmd(CMD_REMOVE_FIRST, 0, 32'h0), 1'b0);
        send_command(make_cmd(CMD_REMOVE_LAST, 0, 32'h0), 1'b0);
        send_command(make_cmd(CMD_REMOVE_AT, 0, 32'h0), 1'b0);
        send_command(make_cmd(CMD_READ, 0, 32'h0), 1'b0);

        // random: alternate growing and shrinking runs so the list hits full and empty
        growing = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 700 && n < 1000);
            lvl   = mirror.fill;
            if (lvl >= CAPACITY) growing = 1'b0;
            else if (lvl == 0) growing = 1'b1;
            else if ($urandom_range(0, 99) < 3) growing = !growing;

            roll = $urandom_range(0, 99);
            if (($urandom_range(0, 99) < 20)) begin
                case ($urandom_range(0, 3))
                    0:       w = 32'h8000_0000;
                    1:       w = 32'h7FFF_FFFF;
                    2:       w = 32'h0;
                    default: w = 32'hFFFF_FFFF;
                endcase
            end else begin
                w = $urandom;
            end

            if (roll < 10) begin
                // noise: any command at any index
                it = make_cmd(t_cmd'($urandom_range(0, 7)), $urandom_range(0, 31), w);
            end else begin
                if (roll < 60) begin
                    case ($urandom_range(0, 2))
                        0:       it.cmd = growing ? CMD_APPEND : CMD_REMOVE_LAST;
                        1:       it.cmd = growing ? CMD_PREPEND : CMD_REMOVE_FIRST;
                        default: it.cmd = growing ? CMD_INSERT : CMD_REMOVE_AT;
                    endcase
                end else begin
                    it.cmd = t_cmd'($urandom_range(0, 7));
                end
                it.position = POS_W'($urandom_range(0, lvl));
                it.word_in  = w;
            end
            send_command(it, !quiet);
        end

        @(negedge i_clk);
        i_start <= 1'b0;

        // drain the outstanding results, then allow for the pipeline depth
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mirror.fails == 0 && mirror.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/isl_pkg.sv
hdl/isl_decode.sv
hdl/isl_store.sv
hdl/indexed_sequence_list_unit.sv
dv/indexed_sequence_list_unit_test.sv
